// ===== src/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg: packed pixel to RGBA8 shared definitions
// Format codes, pipeline stage records and channel widening/rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

	localparam logic [4:0] FMT_XRGB32    = 5'd0;
	localparam logic [4:0] FMT_ARGB32    = 5'd1;
	localparam logic [4:0] FMT_ARGB32P   = 5'd2;
	localparam logic [4:0] FMT_RGB565    = 5'd3;
	localparam logic [4:0] FMT_ARGB8565P = 5'd4;
	localparam logic [4:0] FMT_RGB666    = 5'd5;
	localparam logic [4:0] FMT_ARGB6666P = 5'd6;
	localparam logic [4:0] FMT_RGB555    = 5'd7;
	localparam logic [4:0] FMT_ARGB8555P = 5'd8;
	localparam logic [4:0] FMT_RGB888    = 5'd9;
	localparam logic [4:0] FMT_RGB444    = 5'd10;
	localparam logic [4:0] FMT_ARGB4444P = 5'd11;
	localparam logic [4:0] FMT_RGBX8888  = 5'd12;
	localparam logic [4:0] FMT_RGBA8888  = 5'd13;
	localparam logic [4:0] FMT_RGBA8888P = 5'd14;
	localparam logic [4:0] FMT_BGR30     = 5'd15;
	localparam logic [4:0] FMT_A2BGR30P  = 5'd16;
	localparam logic [4:0] FMT_RGB30     = 5'd17;
	localparam logic [4:0] FMT_A2RGB30P  = 5'd18;
	localparam logic [4:0] FMT_ALPHA8    = 5'd19;
	localparam logic [4:0] FMT_GRAY8     = 5'd20;
	localparam logic [4:0] FMT_RGBX64    = 5'd21;
	localparam logic [4:0] FMT_RGBA64    = 5'd22;
	localparam logic [4:0] FMT_RGBA64P   = 5'd23;
	localparam logic [4:0] FMT_GRAY16    = 5'd24;
	localparam logic [4:0] FMT_BGR888    = 5'd25;

	localparam int QW = 16;

	typedef enum logic [1:0] {
		DOM_8  = 2'd0,
		DOM_10 = 2'd1,
		DOM_16 = 2'd2
	} dom_t;

	typedef struct packed {
		logic             vld;
		logic             bad;
		logic             pm;
		dom_t             dom;
		logic [15:0]      a;
		logic [7:0]       alpha8;
		logic [2:0][15:0] c;
	} dec_t;

	typedef struct packed {
		logic        sat;
		logic [15:0] rem;
		logic [15:0] num;
		logic [15:0] q;
	} ch_t;

	typedef struct packed {
		logic           vld;
		logic           bad;
		logic           pm;
		logic           zero;
		dom_t           dom;
		logic [15:0]    a;
		logic [7:0]     alpha8;
		ch_t  [2:0]     ch;
	} div_t;

	function automatic logic [7:0] rep4(input logic [3:0] v);
		rep4 = {v, v};
	endfunction

	function automatic logic [7:0] rep5(input logic [4:0] v);
		rep5 = {v, v[4:2]};
	endfunction

	function automatic logic [7:0] rep6(input logic [5:0] v);
		rep6 = {v, v[5:4]};
	endfunction

	// round(v * 255 / 1023)
	function automatic logic [7:0] conv10(input logic [9:0] v);
		logic [18:0] x;
		logic [18:0] s;
		x = ({9'd0, v} << 8) - {9'd0, v} + 19'd511;
		s = x + (x >> 10) + 19'd1;
		conv10 = s[17:10];
	endfunction

	// round(v * 255 / 65535)
	function automatic logic [7:0] conv16(input logic [15:0] v);
		logic [24:0] x;
		logic [24:0] s;
		x = ({9'd0, v} << 8) - {9'd0, v} + 25'd32767;
		s = x + (x >> 16) + 25'd1;
		conv16 = s[23:16];
	endfunction

endpackage

`default_nettype wire

// ===== src/packed_pixel_to_rgba8_top.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_to_rgba8_top: packed pixel to straight RGBA8 converter
// Decodes 26 pixel formats and unpremultiplies through a radix-2 divider
// pipeline, one quotient bit per stage for all three colour channels.
// ----------------------------------------------------------------------------
//  port group | direction | handshake            | payload
//  input      | in        | in_valid / in_stall  | format_code, pixel_bytes
//  output     | out       | out_valid / out_stall| red, green, blue, alpha_out,
//             |           |                      | bad_format
//
//  One item per cycle while the output is not stalled; pipeline registers are
//  decode, numerator, 16 divide stages, rounding/output. The divider chain sets the depth.
//  Reset clears all stage valid bits; payload registers are not reset.
//  An output stall while out_valid is high freezes the whole pipeline and is passed to in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_to_rgba8_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  format_code,
	input  wire logic [63:0] pixel_bytes,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha_out,
	output logic             bad_format
);

	logic adv;
	ppr_pkg::dec_t dec_d;
	ppr_pkg::dec_t dec_s1;
	ppr_pkg::div_t div_d;
	ppr_pkg::div_t div_sn [0:ppr_pkg::QW];
	logic [7:0] red_q, green_q, blue_q, alpha_q;
	logic bad_q, out_vld_q;
	logic [2:0][7:0] fin_c;

	assign adv = !(out_vld_q && out_stall);
	assign in_stall = !adv;

	// decode
	always_comb begin
		logic [7:0]  b0, b1, b2, b3;
		logic [15:0] w16, be16;
		logic [23:0] be24;
		logic [31:0] w32;
		b0 = pixel_bytes[7:0];
		b1 = pixel_bytes[15:8];
		b2 = pixel_bytes[23:16];
		b3 = pixel_bytes[31:24];
		w32 = pixel_bytes[31:0];
		w16 = pixel_bytes[15:0];
		be16 = {b0, b1};
		be24 = {b0, b1, b2};
		dec_d = '0;
		dec_d.vld = in_valid;
		dec_d.dom = ppr_pkg::DOM_8;
		dec_d.alpha8 = 8'hff;
		unique case (format_code)
			ppr_pkg::FMT_XRGB32, ppr_pkg::FMT_BGR888: begin
				dec_d.c = {8'd0, b0, 8'd0, b1, 8'd0, b2};
			end
			ppr_pkg::FMT_ARGB32: begin
				dec_d.c = {8'd0, b0, 8'd0, b1, 8'd0, b2};
				dec_d.alpha8 = b3;
			end
			ppr_pkg::FMT_ARGB32P: begin
				dec_d.c = {8'd0, b0, 8'd0, b1, 8'd0, b2};
				dec_d.alpha8 = b3;
				dec_d.a = {8'd0, b3};
				dec_d.pm = 1'b1;
			end
			ppr_pkg::FMT_RGB565: begin
				dec_d.c = {8'd0, ppr_pkg::rep5(w16[4:0]), 8'd0, ppr_pkg::rep6(w16[10:5]),
					8'd0, ppr_pkg::rep5(w16[15:11])};
			end
			ppr_pkg::FMT_ARGB8565P: begin
				dec_d.c = {8'd0, ppr_pkg::rep5(be16[4:0]), 8'd0, ppr_pkg::rep6(be16[10:5]),
					8'd0, ppr_pkg::rep5(be16[15:11])};
				dec_d.alpha8 = b2;
				dec_d.a = {8'd0, b2};
				dec_d.pm = 1'b1;
			end
			ppr_pkg::FMT_RGB666: begin
				dec_d.c = {8'd0, ppr_pkg::rep6(be24[5:0]), 8'd0, ppr_pkg::rep6(be24[11:6]),
					8'd0, ppr_pkg::rep6(be24[17:12])};
			end
			ppr_pkg::FMT_ARGB6666P: begin
				dec_d.c = {8'd0, ppr_pkg::rep6(be24[5:0]), 8'd0, ppr_pkg::rep6(be24[11:6]),
					8'd0, ppr_pkg::rep6(be24[17:12])};
				dec_d.alpha8 = ppr_pkg::rep6(be24[23:18]);
				dec_d.a = {8'd0, ppr_pkg::rep6(be24[23:18])};
				dec_d.pm = 1'b1;
			end
			ppr_pkg::FMT_RGB555: begin
				dec_d.c = {8'd0, ppr_pkg::rep5(w16[4:0]), 8'd0, ppr_pkg::rep5(w16[9:5]),
					8'd0, ppr_pkg::rep5(w16[14:10])};
			end
			ppr_pkg::FMT_ARGB8555P: begin
				dec_d.c = {8'd0, ppr_pkg::rep5(be16[4:0]), 8'd0, ppr_pkg::rep5(be16[9:5]),
					8'd0, ppr_pkg::rep5(be16[14:10])};
				dec_d.alpha8 = b2;
				dec_d.a = {8'd0, b2};
				dec_d.pm = 1'b1;
			end
			ppr_pkg::FMT_RGB888, ppr_pkg::FMT_RGBX8888: begin
				dec_d.c = {8'd0, b2, 8'd0, b1, 8'd0, b0};
			end
			ppr_pkg::FMT_RGB444: begin
				dec_d.c = {8'd0, ppr_pkg::rep4(w16[3:0]), 8'd0, ppr_pkg::rep4(w16[7:4]),
					8'd0, ppr_pkg::rep4(w16[11:8])};
			end
			ppr_pkg::FMT_ARGB4444P: begin
				dec_d.c = {8'd0, ppr_pkg::rep4(w16[3:0]), 8'd0, ppr_pkg::rep4(w16[7:4]),
					8'd0, ppr_pkg::rep4(w16[11:8])};
				dec_d.alpha8 = ppr_pkg::rep4(w16[15:12]);
				dec_d.a = {8'd0, ppr_pkg::rep4(w16[15:12])};
				dec_d.pm = 1'b1;
			end
			ppr_pkg::FMT_RGBA8888: begin
				dec_d.c = {8'd0, b2, 8'd0, b1, 8'd0, b0};
				dec_d.alpha8 = b3;
			end
			ppr_pkg::FMT_RGBA8888P: begin
				dec_d.c = {8'd0, b2, 8'd0, b1, 8'd0, b0};
				dec_d.alpha8 = b3;
				dec_d.a = {8'd0, b3};
				dec_d.pm = 1'b1;
			end
			ppr_pkg::FMT_BGR30, ppr_pkg::FMT_A2BGR30P: begin
				dec_d.dom = ppr_pkg::DOM_10;
				dec_d.c = {6'd0, w32[29:20], 6'd0, w32[19:10], 6'd0, w32[9:0]};
				if (format_code == ppr_pkg::FMT_A2BGR30P) begin
					dec_d.pm = 1'b1;
					dec_d.a = {14'd0, w32[31:30]};
					dec_d.alpha8 = {w32[31:30], w32[31:30], w32[31:30], w32[31:30]};
				end
			end
			ppr_pkg::FMT_RGB30, ppr_pkg::FMT_A2RGB30P: begin
				dec_d.dom = ppr_pkg::DOM_10;
				dec_d.c = {6'd0, w32[9:0], 6'd0, w32[19:10], 6'd0, w32[29:20]};
				if (format_code == ppr_pkg::FMT_A2RGB30P) begin
					dec_d.pm = 1'b1;
					dec_d.a = {14'd0, w32[31:30]};
					dec_d.alpha8 = {w32[31:30], w32[31:30], w32[31:30], w32[31:30]};
				end
			end
			ppr_pkg::FMT_ALPHA8: begin
				dec_d.alpha8 = b0;
			end
			ppr_pkg::FMT_GRAY8: begin
				dec_d.c = {8'd0, b0, 8'd0, b0, 8'd0, b0};
			end
			ppr_pkg::FMT_RGBX64, ppr_pkg::FMT_RGBA64, ppr_pkg::FMT_RGBA64P: begin
				dec_d.dom = ppr_pkg::DOM_16;
				dec_d.c = {pixel_bytes[47:32], pixel_bytes[31:16], pixel_bytes[15:0]};
				dec_d.a = (format_code == ppr_pkg::FMT_RGBX64) ? 16'hffff
					: pixel_bytes[63:48];
				dec_d.pm = (format_code == ppr_pkg::FMT_RGBA64P);
			end
			ppr_pkg::FMT_GRAY16: begin
				dec_d.dom = ppr_pkg::DOM_16;
				dec_d.c = {w16, w16, w16};
				dec_d.a = 16'hffff;
			end
			default: begin
				dec_d.bad = 1'b1;
				dec_d.alpha8 = 8'd0;
			end
		endcase
	end

	// numerator c*amax + a/2 and saturation test against (cmax+1)*a
	always_comb begin
		logic [31:0] cm;
		logic [31:0] n;
		logic [32:0] lim;
		div_d = '0;
		div_d.vld = dec_s1.vld;
		div_d.bad = dec_s1.bad;
		div_d.pm = dec_s1.pm;
		div_d.zero = (dec_s1.a == 16'd0);
		div_d.dom = dec_s1.dom;
		div_d.a = dec_s1.a;
		div_d.alpha8 = dec_s1.alpha8;
		for (int i = 0; i < 3; i++) begin
			case (dec_s1.dom)
				ppr_pkg::DOM_10: begin
					cm = ({16'd0, dec_s1.c[i]} << 1) + {16'd0, dec_s1.c[i]};
					lim = {17'd0, dec_s1.a} << 10;
				end
				ppr_pkg::DOM_16: begin
					cm = ({16'd0, dec_s1.c[i]} << 16) - {16'd0, dec_s1.c[i]};
					lim = {17'd0, dec_s1.a} << 16;
				end
				default: begin
					cm = ({16'd0, dec_s1.c[i]} << 8) - {16'd0, dec_s1.c[i]};
					lim = {17'd0, dec_s1.a} << 8;
				end
			endcase
			n = cm + {17'd0, dec_s1.a[15:1]};
			if (dec_s1.pm) begin
				div_d.ch[i].sat = ({1'b0, n} >= lim);
				div_d.ch[i].rem = n[31:16];
				div_d.ch[i].num = n[15:0];
				div_d.ch[i].q = 16'd0;
			end else begin
				div_d.ch[i].q = dec_s1.c[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_s1.vld <= 1'b0;
			div_sn[0].vld <= 1'b0;
		end else if (adv) begin
			dec_s1 <= dec_d;
			div_sn[0] <= div_d;
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar j = 0; j < ppr_pkg::QW; j++) begin : g_div
		localparam int B = ppr_pkg::QW - 1 - j;
		ppr_pkg::div_t nxt;

		always_comb begin
			logic [16:0] r2;
			nxt = div_sn[j];
			for (int i = 0; i < 3; i++) begin
				r2 = {div_sn[j].ch[i].rem, div_sn[j].ch[i].num[B]};
				if (div_sn[j].pm) begin
					if (r2 >= {1'b0, div_sn[j].a}) begin
						nxt.ch[i].rem = 16'(r2 - {1'b0, div_sn[j].a});
						nxt.ch[i].q[B] = 1'b1;
					end else begin
						nxt.ch[i].rem = r2[15:0];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_sn[j+1].vld <= 1'b0;
			end else if (adv) begin
				div_sn[j+1] <= nxt;
			end
		end
	end

	// clamp and round to 8 bits
	always_comb begin
		logic [15:0] v;
		for (int i = 0; i < 3; i++) begin
			v = div_sn[ppr_pkg::QW].ch[i].q;
			if (div_sn[ppr_pkg::QW].pm) begin
				if (div_sn[ppr_pkg::QW].zero) begin
					v = 16'd0;
				end else if (div_sn[ppr_pkg::QW].ch[i].sat) begin
					case (div_sn[ppr_pkg::QW].dom)
						ppr_pkg::DOM_10: v = 16'h03ff;
						ppr_pkg::DOM_16: v = 16'hffff;
						default:         v = 16'h00ff;
					endcase
				end
			end
			case (div_sn[ppr_pkg::QW].dom)
				ppr_pkg::DOM_10: fin_c[i] = ppr_pkg::conv10(v[9:0]);
				ppr_pkg::DOM_16: fin_c[i] = ppr_pkg::conv16(v);
				default:         fin_c[i] = v[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= div_sn[ppr_pkg::QW].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q <= fin_c[0];
			green_q <= fin_c[1];
			blue_q <= fin_c[2];
			alpha_q <= (div_sn[ppr_pkg::QW].dom == ppr_pkg::DOM_16)
				? ppr_pkg::conv16(div_sn[ppr_pkg::QW].a) : div_sn[ppr_pkg::QW].alpha8;
			bad_q <= div_sn[ppr_pkg::QW].bad;
		end
	end

	assign out_valid = out_vld_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
	assign alpha_out = alpha_q;
	assign bad_format = bad_q;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_format) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0
			&& alpha_out == 8'd0))
		else $error("bad format item carries nonzero color");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(div_sn[ppr_pkg::QW].vld)
			&& $stable(dec_s1.vld))
		else $error("pipeline moved under output stall");

	a_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && div_sn[ppr_pkg::QW].vld && div_sn[ppr_pkg::QW].pm
			&& div_sn[ppr_pkg::QW].zero) |=> (red == 8'd0 && green == 8'd0
			&& blue == 8'd0))
		else $error("zero alpha premultiplied item gave color");

endmodule

`default_nettype wire
